[hw/rtl/trie_pkg.sv]
package trie_pkg;

   // node pool and alphabet
   localparam int POOL_NODES = 4096;
   localparam int NODE_W     = $clog2(POOL_NODES);
   localparam int LETTERS    = 26;
   localparam int LETTER_W   = 5;
   localparam int CODE_W     = $clog2(LETTERS);

   // operation codes
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_FIND   = 1'b1;

   typedef logic [NODE_W-1:0] node_type;
   typedef logic [LETTERS-1:0][NODE_W-1:0] child_row_type;

   localparam int ROW_W = LETTERS * NODE_W;

endpackage

[hw/rtl/trie_if.sv]
interface trie_req_if;
   import trie_pkg::*;

   logic                valid;
   logic                ready;
   logic                operation;
   logic [LETTER_W-1:0] letter;
   logic                last_letter;

   modport source (output valid, output operation, output letter, output last_letter,
                   input ready);
   modport sink   (input valid, input operation, input letter, input last_letter,
                   output ready);
endinterface

interface trie_rsp_if;
   import trie_pkg::*;

   logic              valid;
   logic              ready;
   logic              found;
   logic              table_full;
   logic [NODE_W-1:0] end_node;

   modport source (output valid, output found, output table_full, output end_node,
                   input ready);
   modport sink   (input valid, input found, input table_full, input end_node,
                   output ready);
endinterface

[hw/rtl/trie_ram.sv]
module trie_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[hw/rtl/trie_word_insert_lookup.sv]
// Prefix tree over the letters a..z, one letter per transaction.
//
// req_ch carries operation (insert or find), letter and last_letter. Each
// word is a run of letters closed by a transaction with last_letter set; only
// that closing transaction yields a transaction on rsp_ch, with found,
// table_full and end_node.
//
// Steps: a letter that walks the tree goes through the child row read, then the
// link update with allocation written back into the same row. A last letter
// goes on to a finish step, in which the word-end mark of the reached node is
// checked or set and its result is written into the output register. Letters
// that follow a miss or an overflow skip the walk, and go straight to the
// finish step when they close the word. The child-row memory read is
// registered, so no new letter is taken until a walking letter is done.
//
// Reset: the block first sweeps both memories, one node row per cycle, over
// all POOL_NODES rows (4096); req_ch.ready stays low during the sweep.
//
// Stall: a waiting result does not block further letters. Only a last letter
// that finds the output register still full holds until rsp_ch.ready.
module trie_word_insert_lookup (
   input  logic        clock,
   input  logic        reset,
   trie_req_if.sink    req_ch,
   trie_rsp_if.source  rsp_ch
);
   import trie_pkg::*;

   localparam logic [1:0] S_CLEAR  = 2'd0;
   localparam logic [1:0] S_IDLE   = 2'd1;
   localparam logic [1:0] S_WALK   = 2'd2;
   localparam logic [1:0] S_FINISH = 2'd3;

   logic [1:0]        state_ff, state_in;
   node_type          clear_addr_ff, clear_addr_in;
   logic              op_ff, op_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic              last_ff, last_in;
   node_type          cur_node_ff, cur_node_in;
   logic [NODE_W:0]   next_free_ff, next_free_in;
   logic              missed_ff, missed_in;
   logic              overflow_ff, overflow_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic              rsp_full_ff, rsp_full_in;
   node_type          rsp_node_ff, rsp_node_in;

   // memory ports
   logic              child_wr_en, child_rd_en;
   node_type          child_wr_addr;
   child_row_type     child_wr_data, child_rd_data;
   logic              mark_wr_en, mark_wr_data, mark_rd_en, mark_rd_data;
   node_type          mark_wr_addr, mark_rd_addr;

   logic              accept;
   logic              skip;
   logic              out_free;
   node_type          link;
   logic              res_found, res_full;
   logic [CODE_W-1:0] req_code;

   trie_ram #(.WIDTH(ROW_W), .DEPTH(POOL_NODES)) u_child_ram (
      .clock   (clock),
      .wr_en   (child_wr_en),
      .wr_addr (child_wr_addr),
      .wr_data (child_wr_data),
      .rd_en   (child_rd_en),
      .rd_addr (cur_node_ff),
      .rd_data (child_rd_data)
   );

   trie_ram #(.WIDTH(1), .DEPTH(POOL_NODES)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_wr_en),
      .wr_addr (mark_wr_addr),
      .wr_data (mark_wr_data),
      .rd_en   (mark_rd_en),
      .rd_addr (mark_rd_addr),
      .rd_data (mark_rd_data)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   // once a word has missed or overflowed, its remaining letters do not walk
   assign skip         = missed_ff || overflow_ff;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign link         = child_rd_data[code_ff];

   // saturate out-of-range letter codes to z
   assign req_code = (req_ch.letter > LETTER_W'(LETTERS - 1)) ?
                     CODE_W'(LETTERS - 1) : CODE_W'(req_ch.letter);

   // word-end resolution, using the operation of the last letter
   always_comb begin
      res_found = 1'b0;
      res_full  = 1'b0;
      if (op_ff == OP_FIND) begin
         res_found = !skip && mark_rd_data;
      end else if (overflow_ff) begin
         res_full = 1'b1;
      end else begin
         res_found = !missed_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      op_in         = op_ff;
      code_in       = code_ff;
      last_in       = last_ff;
      cur_node_in   = cur_node_ff;
      next_free_in  = next_free_ff;
      missed_in     = missed_ff;
      overflow_in   = overflow_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_found_in  = rsp_found_ff;
      rsp_full_in   = rsp_full_ff;
      rsp_node_in   = rsp_node_ff;

      child_rd_en   = 1'b0;
      child_wr_en   = 1'b0;
      child_wr_addr = cur_node_ff;
      child_wr_data = child_rd_data;
      mark_rd_en    = 1'b0;
      mark_rd_addr  = cur_node_ff;
      mark_wr_en    = 1'b0;
      mark_wr_addr  = cur_node_ff;
      mark_wr_data  = 1'b1;

      unique case (state_ff)
         S_CLEAR: begin
            // zero one node row and its mark per cycle
            child_wr_en   = 1'b1;
            child_wr_addr = clear_addr_ff;
            child_wr_data = '0;
            mark_wr_en    = 1'b1;
            mark_wr_addr  = clear_addr_ff;
            mark_wr_data  = 1'b0;
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == NODE_W'(POOL_NODES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               op_in   = req_ch.operation;
               code_in = req_code;
               last_in = req_ch.last_letter;
               if (!skip) begin
                  child_rd_en = 1'b1;
                  state_in    = S_WALK;
               end else if (req_ch.last_letter) begin
                  state_in = S_FINISH;
               end
            end
         end
         S_WALK: begin
            if (link != '0) begin
               cur_node_in = link;
            end else if (op_ff == OP_FIND) begin
               missed_in = 1'b1;
            end else if (next_free_ff < (NODE_W + 1)'(POOL_NODES)) begin
               // allocate: write the new link back into the same row
               child_wr_en            = 1'b1;
               child_wr_data[code_ff] = next_free_ff[NODE_W-1:0];
               cur_node_in            = next_free_ff[NODE_W-1:0];
               next_free_in           = next_free_ff + 1'b1;
            end else begin
               overflow_in = 1'b1;
            end
            // fetch the mark of the node just reached
            mark_rd_en   = 1'b1;
            mark_rd_addr = cur_node_in;
            state_in     = last_ff ? S_FINISH : S_IDLE;
         end
         S_FINISH: begin
            // hold until the output register can take the result
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found;
               rsp_full_in  = res_full;
               rsp_node_in  = res_found ? cur_node_ff : '0;
               mark_wr_en   = (op_ff == OP_INSERT) && res_found;
               cur_node_in  = '0;
               missed_in    = 1'b0;
               overflow_in  = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clear_addr_ff <= '0;
         cur_node_ff   <= '0;
         next_free_ff  <= (NODE_W + 1)'(1);
         missed_ff     <= 1'b0;
         overflow_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         cur_node_ff   <= cur_node_in;
         next_free_ff  <= next_free_in;
         missed_ff     <= missed_in;
         overflow_ff   <= overflow_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      code_ff      <= code_in;
      last_ff      <= last_in;
      rsp_found_ff <= rsp_found_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_node_ff  <= rsp_node_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.found      = rsp_found_ff;
   assign rsp_ch.table_full = rsp_full_ff;
   assign rsp_ch.end_node   = rsp_node_ff;

   // no transaction is taken while the memories are being swept
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ch.ready)
      else $error("request accepted during clearing sweep");

   // the allocation pointer never runs past the pool
   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= (NODE_W + 1)'(POOL_NODES))
      else $error("next free node beyond pool");

   // at most one node is allocated per walk step, and only in the walk state
   a_alloc_step: assert property (@(posedge clock) disable iff (reset)
      (next_free_ff != $past(next_free_ff)) |->
         ($past(state_ff) == S_WALK && next_free_ff == $past(next_free_ff) + 1'b1))
      else $error("unexpected allocation pointer change");

   // an overflowed insert never reports a hit
   a_full_is_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.table_full) |-> (!rsp_ch.found && rsp_ch.end_node == '0))
      else $error("table_full result with hit fields");

endmodule
